### rtl/rdq_pkg.sv
package rdq_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_CHECK = 3'd2;
  localparam logic [2:0] ACT_DONE  = 3'd3;
  localparam logic [2:0] ACT_START = 3'd4;

  // Command modes sent to the disk.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BUSY        = 3'd1;
  localparam logic [2:0] ST_EMPTY_START = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_EMPTY_DONE  = 3'd4;

  // One queued request. Only read and write are ever queued, so one bit holds the mode.
  typedef struct packed {
    logic [7:0]  requester;
    logic        is_write;
    logic [15:0] sector;
    logic [31:0] address;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    logic        issue;
    logic [1:0]  issue_mode;
    logic [2:0]  issue_disk;
    logic [15:0] issue_sector;
    logic [31:0] issue_address;
    logic        wake;
    logic [7:0]  wake_id;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_NEXT
  } ctrl_state_t;

endpackage

### rtl/rdq_store.sv
module rdq_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  we,
  input  logic [AW-1:0]         addr,
  input  rdq_pkg::entry_t       wdata,
  output rdq_pkg::entry_t       rdata
);
  import rdq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rdq_ptr_file.sv
module rdq_ptr_file #(
  parameter int NUM_DISKS   = 8,
  parameter int QUEUE_DEPTH = 16,
  localparam int DIW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1,
  localparam int PW  = $clog2(QUEUE_DEPTH),
  localparam int CW  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [DIW-1:0] idx,
  input  logic           idx_ok,
  output logic [PW-1:0]  head,
  output logic [PW-1:0]  tail,
  output logic [CW-1:0]  count,
  input  logic           upd_en,
  input  logic [PW-1:0]  upd_head,
  input  logic [PW-1:0]  upd_tail,
  input  logic [CW-1:0]  upd_count
);
  import rdq_pkg::*;

  logic [PW-1:0] head_r  [NUM_DISKS];
  logic [PW-1:0] tail_r  [NUM_DISKS];
  logic [CW-1:0] count_r [NUM_DISKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DISKS; d++) begin
        head_r[d]  <= '0;
        tail_r[d]  <= '0;
        count_r[d] <= '0;
      end
    end else if (upd_en && idx_ok) begin
      head_r[idx]  <= upd_head;
      tail_r[idx]  <= upd_tail;
      count_r[idx] <= upd_count;
    end
  end

  // A disk number beyond the configured count reads as an empty queue.
  always_comb begin
    head  = '0;
    tail  = '0;
    count = '0;
    if (idx_ok) begin
      head  = head_r[idx];
      tail  = tail_r[idx];
      count = count_r[idx];
    end
  end

endmodule

### rtl/rdq_ctrl.sv
module rdq_ctrl #(
  parameter int NUM_DISKS   = 8,
  parameter int QUEUE_DEPTH = 16,
  localparam int DIW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1,
  localparam int PW  = $clog2(QUEUE_DEPTH),
  localparam int CW  = $clog2(QUEUE_DEPTH + 1),
  localparam int AW  = $clog2(NUM_DISKS * QUEUE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_action,
  input  logic [2:0]           in_disk_id,
  input  logic [15:0]          in_sector,
  input  logic [31:0]          in_buffer_address,
  input  logic [7:0]           in_requester,
  input  logic                 in_disk_free,
  input  logic                 slot_free,
  output logic                 res_load,
  output rdq_pkg::result_t     res,
  output logic                 mem_en,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_addr,
  output rdq_pkg::entry_t      mem_wdata,
  input  rdq_pkg::entry_t      mem_rdata,
  output logic [DIW-1:0]       ptr_idx,
  output logic                 ptr_ok,
  input  logic [PW-1:0]        ptr_head,
  input  logic [PW-1:0]        ptr_tail,
  input  logic [CW-1:0]        ptr_count,
  output logic                 upd_en,
  output logic [PW-1:0]        upd_head,
  output logic [PW-1:0]        upd_tail,
  output logic [CW-1:0]        upd_count
);
  import rdq_pkg::*;

  ctrl_state_t   state_r, state_nxt;
  logic [2:0]    action_r;
  logic [2:0]    disk_r;
  logic [15:0]   sector_r;
  logic [31:0]   addr_r;
  logic [7:0]    req_r;
  logic          free_r;
  logic [7:0]    done_req_r;
  logic          done_load;
  logic          accept;
  logic [2:0]    disk_sel;
  logic [DIW+2:0] disk_ext;
  logic          count_zero;
  logic          full;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [DIW-1:0] d,
                                              input logic [PW-1:0] p);
    return AW'(AW'(d) * AW'(QUEUE_DEPTH)) + AW'(p);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // The pointer file is read at the incoming disk while idle, else at the held one.
  assign disk_sel   = (state_r == S_IDLE) ? in_disk_id : disk_r;
  assign disk_ext   = {{DIW{1'b0}}, disk_sel};
  assign ptr_idx    = disk_ext[DIW-1:0];
  assign ptr_ok     = disk_ext < (DIW + 3)'(NUM_DISKS);
  assign count_zero = (ptr_count == '0);
  assign full       = (ptr_count == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      disk_r   <= in_disk_id;
      sector_r <= in_sector;
      addr_r   <= in_buffer_address;
      req_r    <= in_requester;
      free_r   <= in_disk_free;
    end
    if (done_load) begin
      done_req_r <= mem_rdata.requester;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_load  = 1'b0;
    res       = '0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = slot_addr(ptr_idx, ptr_head);
    mem_wdata = '{requester: req_r, is_write: (action_r == ACT_WRITE),
                  sector: sector_r, address: addr_r};
    upd_en    = 1'b0;
    upd_head  = ptr_head;
    upd_tail  = ptr_tail;
    upd_count = ptr_count;
    done_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Fetch the head entry of the addressed queue.
          mem_en    = ptr_ok;
          state_nxt = S_HEAD;
        end
      end

      S_HEAD: begin
        res.issue_disk = disk_r;
        if (ptr_ok && action_r == ACT_DONE && !count_zero) begin
          // Pop the finished entry and fetch the one behind it.
          done_load = 1'b1;
          upd_en    = 1'b1;
          upd_head  = ptr_inc(ptr_head);
          upd_count = ptr_count - 1'b1;
          mem_en    = 1'b1;
          mem_addr  = slot_addr(ptr_idx, ptr_inc(ptr_head));
          state_nxt = S_NEXT;
        end else if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          if (ptr_ok) begin
            unique case (action_r)
              ACT_READ, ACT_WRITE: begin
                if (full) begin
                  res.status = ST_FULL;
                end else begin
                  if (free_r && count_zero) begin
                    res.issue         = 1'b1;
                    res.issue_mode    = (action_r == ACT_WRITE) ? MODE_WRITE : MODE_READ;
                    res.issue_sector  = sector_r;
                    res.issue_address = addr_r;
                  end
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = slot_addr(ptr_idx, ptr_tail);
                  upd_en    = 1'b1;
                  upd_tail  = ptr_inc(ptr_tail);
                  upd_count = ptr_count + 1'b1;
                end
              end
              ACT_CHECK: begin
                if (free_r && count_zero) begin
                  res.issue      = 1'b1;
                  res.issue_mode = MODE_CHECK;
                end else begin
                  res.status = ST_BUSY;
                end
              end
              ACT_DONE: begin
                res.status = ST_EMPTY_DONE;
              end
              ACT_START: begin
                if (count_zero) begin
                  res.status = ST_EMPTY_START;
                end else if (free_r) begin
                  res.issue         = 1'b1;
                  res.issue_mode    = MODE_WRITE;
                  res.issue_sector  = mem_rdata.sector;
                  res.issue_address = mem_rdata.address;
                end
              end
              default: begin
              end
            endcase
          end
          if (!res.issue) begin
            res.issue_disk = '0;
          end
        end
      end

      S_NEXT: begin
        if (slot_free) begin
          res_load    = 1'b1;
          state_nxt   = S_IDLE;
          res.wake    = 1'b1;
          res.wake_id = done_req_r;
          if (!count_zero) begin
            res.issue         = 1'b1;
            res.issue_mode    = mem_rdata.is_write ? MODE_WRITE : MODE_READ;
            res.issue_disk    = disk_r;
            res.issue_sector  = mem_rdata.sector;
            res.issue_address = mem_rdata.address;
            if (mem_rdata.requester == done_req_r) begin
              res.wake = 1'b0;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/per_disk_request_queue.sv
// Per-disk request queue. The block keeps one first-in first-out queue of disk
// requests for each of NUM_DISKS disks, QUEUE_DEPTH entries deep, and answers every
// input transaction with exactly one result transaction. A read or write request is
// appended to its disk's queue and is also sent to the disk at once when the disk
// reports free and its queue was empty; a request to a full queue is dropped with
// status 3. A check goes out only to a free disk with an empty queue, otherwise it
// reports busy. A completion pops the head entry, sends the next entry if one
// waits, and wakes the finished requester unless the next entry is its own; a
// completion on an empty queue reports status 4. A start-write resends the head
// entry as a write when the disk is free, and reports status 2 on an empty queue.
// Disk numbers at or above NUM_DISKS and unknown actions give an all-zero result.
// All queued entries live in one single-port store with a one-cycle registered
// read; the head, tail and fill count of each disk sit in a small pointer file.
// One transaction at a time is worked on: an item takes two cycles (accept and
// head read), and a completion that pops a non-empty queue takes three, since it
// must read the entry behind the head from the same store port. The finished
// result sits in an output register, so the next transaction is accepted while
// the previous result still waits on out_stall; a new result only waits when that
// register has not yet been emptied.
module per_disk_request_queue #(
  parameter int NUM_DISKS   = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_disk_id,
  input  logic [15:0] in_sector,
  input  logic [31:0] in_buffer_address,
  input  logic [7:0]  in_requester,
  input  logic        in_disk_free,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_issue,
  output logic [1:0]  out_issue_mode,
  output logic [2:0]  out_issue_disk,
  output logic [15:0] out_issue_sector,
  output logic [31:0] out_issue_address,
  output logic        out_wake,
  output logic [7:0]  out_wake_id,
  output logic [2:0]  out_status
);
  import rdq_pkg::*;

  localparam int DIW   = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_DISKS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic           mem_en;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  entry_t         mem_wdata;
  entry_t         mem_rdata;

  logic [DIW-1:0] ptr_idx;
  logic           ptr_ok;
  logic [PW-1:0]  ptr_head;
  logic [PW-1:0]  ptr_tail;
  logic [CW-1:0]  ptr_count;
  logic           upd_en;
  logic [PW-1:0]  upd_head;
  logic [PW-1:0]  upd_tail;
  logic [CW-1:0]  upd_count;

  logic           slot_free;
  logic           res_load;
  result_t        res;

  logic           out_valid_r;
  result_t        out_r;

  // Holds every queued request of every disk, one region of QUEUE_DEPTH entries per disk.
  rdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Head, tail and fill count for each disk, cleared by reset.
  rdq_ptr_file #(
    .NUM_DISKS   (NUM_DISKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ptr_file (
    .clk       (clk),
    .rst_n     (rst_n),
    .idx       (ptr_idx),
    .idx_ok    (ptr_ok),
    .head      (ptr_head),
    .tail      (ptr_tail),
    .count     (ptr_count),
    .upd_en    (upd_en),
    .upd_head  (upd_head),
    .upd_tail  (upd_tail),
    .upd_count (upd_count)
  );

  // Sequencer: accepts a transaction, reads the store, updates the queue and builds the result.
  rdq_ctrl #(
    .NUM_DISKS   (NUM_DISKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_disk_id        (in_disk_id),
    .in_sector         (in_sector),
    .in_buffer_address (in_buffer_address),
    .in_requester      (in_requester),
    .in_disk_free      (in_disk_free),
    .slot_free         (slot_free),
    .res_load          (res_load),
    .res               (res),
    .mem_en            (mem_en),
    .mem_we            (mem_we),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata),
    .ptr_idx           (ptr_idx),
    .ptr_ok            (ptr_ok),
    .ptr_head          (ptr_head),
    .ptr_tail          (ptr_tail),
    .ptr_count         (ptr_count),
    .upd_en            (upd_en),
    .upd_head          (upd_head),
    .upd_tail          (upd_tail),
    .upd_count         (upd_count)
  );

  // The output register can take a new result when it is empty or is being drained now.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_issue         = out_r.issue;
  assign out_issue_mode    = out_r.issue_mode;
  assign out_issue_disk    = out_r.issue_disk;
  assign out_issue_sector  = out_r.issue_sector;
  assign out_issue_address = out_r.issue_address;
  assign out_wake          = out_r.wake;
  assign out_wake_id       = out_r.wake_id;
  assign out_status        = out_r.status;

endmodule
